>>> sv/temporal_constraint_monitor_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the temporal constraint monitor
// Checks compile away when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef TEMPORAL_CONSTRAINT_MONITOR_MACROS_SVH
`define TEMPORAL_CONSTRAINT_MONITOR_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define TCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never be true outside reset
`define TCM_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TCM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCM_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> sv/tcm_pkg.sv
// ---------------------------------------------------------------------------
// tcm_pkg
// Types, constants and decode helpers shared by the monitor's modules.
// ---------------------------------------------------------------------------
package tcm_pkg;

    localparam int MAX_CONSTRAINTS = 8;
    localparam int NODE_COUNT      = 8;
    localparam int SET_COUNT       = 8;

    localparam int FIELD_W     = 3;
    localparam int STATE_W     = 64;
    localparam int STATE_IDX_W = $clog2(STATE_W);
    localparam int COUNT_W     = $clog2(MAX_CONSTRAINTS + 1);
    localparam int SLOT_W      = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
    localparam int SET_COUNT_W = $clog2(SET_COUNT + 1);
    localparam int IDX_W       = FIELD_W + SET_COUNT_W + 1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    // Constraint codes
    localparam logic [FIELD_W-1:0] LALLTRUE  = 3'd0;
    localparam logic [FIELD_W-1:0] LALLFALSE = 3'd1;
    localparam logic [FIELD_W-1:0] PALLTRUE  = 3'd2;
    localparam logic [FIELD_W-1:0] PALLFALSE = 3'd3;
    localparam logic [FIELD_W-1:0] UALLTRUE  = 3'd4;
    localparam logic [FIELD_W-1:0] UALLFALSE = 3'd5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_END        = 2'd0,
        KIND_ALWAYS     = 2'd1,
        KIND_EVENTUALLY = 2'd2
    } kind_t;

    typedef struct packed {
        logic load;   // input beat taken this cycle
        logic visit;  // check the slot under the walk pointer
    } cmd_t;

    typedef struct packed {
        logic eval_start; // incoming beat is an evaluate with a state present
        logic walk_end;   // walk pointer has passed the last stored slot
        logic slot_fail;  // current slot fails
    } status_t;

    function automatic kind_t code_kind(input logic [FIELD_W-1:0] code);
        kind_t k;
        k = KIND_END;
        if (code == PALLTRUE || code == PALLFALSE)
        begin
            k = KIND_ALWAYS;
        end
        else if (code == UALLTRUE || code == UALLFALSE)
        begin
            k = KIND_EVENTUALLY;
        end
        return k;
    endfunction

endpackage

>>> sv/temporal_constraint_monitor.sv
// ---------------------------------------------------------------------------
// temporal_constraint_monitor
// Table of up to eight always / eventually / at-end constraints checked
// against a state bit vector, one stored constraint per cycle.
// ---------------------------------------------------------------------------
//  channel  | dir | tuser         | tdata
//  s_axis   | in  | operation     | node, set, code, state bits, final, present
//  m_axis   | out | -             | verdict, accepted, has_box, has_diamond, count
//
//  Clear, add, the unused operation and an absent-state evaluate: accept, then
//  offer the result beat on the next cycle. Evaluate then walks the stored
//  constraints one per cycle, stopping at the first failure or past the last.
//  Input is taken again the cycle after the result beat.
//  The block takes one beat at a time; a result held by m_tready stalls input.
//  rst_n clears the count, sticky flags and win flag; table entries are not reset.
// ---------------------------------------------------------------------------
module temporal_constraint_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] node_index, [5:3] set_index, [8:6] constraint_code,
    // [72:9] state_bits, [73] final_state, [74] state_present
    input  logic [tcm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] verdict, [1] accepted, [2] has_box, [3] has_diamond, [7:4] constraint_count
    output logic [tcm_pkg::M_TDATA_W-1:0]   m_tdata
);

    tcm_pkg::cmd_t    cmd;
    tcm_pkg::status_t status;

    logic       verdict;
    logic       accepted;
    logic       has_box;
    logic       has_diamond;
    logic [3:0] constraint_count;

    tcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    tcm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .operation        (s_tuser),
        .node_index       (s_tdata[2:0]),
        .set_index        (s_tdata[5:3]),
        .constraint_code  (s_tdata[8:6]),
        .state_bits       (s_tdata[72:9]),
        .final_state      (s_tdata[73]),
        .state_present    (s_tdata[74]),
        .status           (status),
        .verdict          (verdict),
        .accepted         (accepted),
        .has_box          (has_box),
        .has_diamond      (has_diamond),
        .constraint_count (constraint_count)
    );

    assign m_tdata = {constraint_count, has_diamond, has_box, accepted, verdict};

endmodule

>>> sv/tcm_ctrl.sv
// ---------------------------------------------------------------------------
// tcm_ctrl
// Sequencer: takes a beat, walks the table for an evaluate with a state present, offers the result.
// ---------------------------------------------------------------------------
`include "temporal_constraint_monitor_macros.svh"

module tcm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             m_tready,
    input  tcm_pkg::status_t status,
    output logic             s_tready,
    output logic             m_tvalid,
    output tcm_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.eval_start ? ST_WALK : ST_RESP;
                end
            end
            ST_WALK:
            begin
                cmd.visit = 1'b1;
                if (status.walk_end || status.slot_fail)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TCM_NEVER(a_ready_with_result, clk, rst_n, s_tready && m_tvalid, "input taken while result pending")
    `TCM_ASSERT(a_walk_leads_to_result, clk, rst_n, (cmd.visit && (status.walk_end || status.slot_fail)) |=> m_tvalid, "walk finished without result")
    `TCM_NEVER(a_state_one_hot, clk, rst_n, !$onehot(state_reg), "controller state not one-hot")

endmodule

>>> sv/tcm_dp.sv
// ---------------------------------------------------------------------------
// tcm_dp
// Constraint table, sticky flags, walk pointer and result registers.
// ---------------------------------------------------------------------------
`include "temporal_constraint_monitor_macros.svh"

module tcm_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcm_pkg::cmd_t                   cmd,
    input  logic [1:0]                      operation,
    input  logic [tcm_pkg::FIELD_W-1:0]     node_index,
    input  logic [tcm_pkg::FIELD_W-1:0]     set_index,
    input  logic [tcm_pkg::FIELD_W-1:0]     constraint_code,
    input  logic [tcm_pkg::STATE_W-1:0]     state_bits,
    input  logic                            final_state,
    input  logic                            state_present,
    output tcm_pkg::status_t                status,
    output logic                            verdict,
    output logic                            accepted,
    output logic                            has_box,
    output logic                            has_diamond,
    output logic [3:0]                      constraint_count
);

    localparam int MAXC = tcm_pkg::MAX_CONSTRAINTS;

    // Table entries: written on add, no reset
    logic [tcm_pkg::FIELD_W-1:0] node_mem   [MAXC];
    logic [tcm_pkg::FIELD_W-1:0] set_mem    [MAXC];
    logic                        wanted_mem [MAXC];
    tcm_pkg::kind_t              kind_mem   [MAXC];

    logic [tcm_pkg::STATE_W-1:0] bits_reg;
    logic                        final_reg;

    logic [tcm_pkg::COUNT_W-1:0] count_reg,    count_next;
    logic [tcm_pkg::COUNT_W-1:0] ptr_reg,      ptr_next;
    logic [MAXC-1:0]             seen_reg,     seen_next;
    logic                        win_reg,      win_next;
    logic                        box_reg,      box_next;
    logic                        dia_reg,      dia_next;
    logic                        verdict_reg,  verdict_next;
    logic                        accepted_reg, accepted_next;

    tcm_pkg::op_t                op;
    tcm_pkg::kind_t              new_kind;
    logic                        add_ok;
    logic [tcm_pkg::SLOT_W-1:0]  wr_slot;
    logic [tcm_pkg::SLOT_W-1:0]  rd_slot;
    logic [tcm_pkg::IDX_W-1:0]   bit_idx;
    logic                        bit_val;
    logic                        match;
    logic                        slot_fail;
    logic                        walk_end;

    assign op       = tcm_pkg::op_t'(operation);
    assign new_kind = tcm_pkg::code_kind(constraint_code);
    assign wr_slot  = count_reg[tcm_pkg::SLOT_W-1:0];
    assign rd_slot  = ptr_reg[tcm_pkg::SLOT_W-1:0];

    assign add_ok = (int'(count_reg) < MAXC)
                 && (constraint_code <= tcm_pkg::UALLFALSE)
                 && (int'(node_index) < tcm_pkg::NODE_COUNT)
                 && (int'(set_index) < tcm_pkg::SET_COUNT);

    // Bit position of the watched node and set in the latched state vector
    assign bit_idx = tcm_pkg::IDX_W'(node_mem[rd_slot])
                   * tcm_pkg::IDX_W'(tcm_pkg::SET_COUNT)
                   + tcm_pkg::IDX_W'(set_mem[rd_slot]);
    assign bit_val = (bit_idx < tcm_pkg::IDX_W'(tcm_pkg::STATE_W))
                   ? bits_reg[bit_idx[tcm_pkg::STATE_IDX_W-1:0]] : 1'b0;
    assign match   = (bit_val == wanted_mem[rd_slot]);

    always_comb
    begin
        unique case (kind_mem[rd_slot])
            tcm_pkg::KIND_ALWAYS:     slot_fail = !match;
            tcm_pkg::KIND_EVENTUALLY: slot_fail = final_reg && !(seen_reg[rd_slot] || match);
            default:                  slot_fail = final_reg && !match;
        endcase
    end

    assign walk_end = (ptr_reg == count_reg);

    assign status.eval_start = (op == tcm_pkg::OP_EVAL) && state_present;
    assign status.walk_end   = walk_end;
    assign status.slot_fail  = slot_fail;

    always_comb
    begin
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        seen_next     = seen_reg;
        win_next      = win_reg;
        box_next      = box_reg;
        dia_next      = dia_reg;
        verdict_next  = verdict_reg;
        accepted_next = accepted_reg;
        if (cmd.load)
        begin
            ptr_next      = '0;
            accepted_next = 1'b0;
            unique case (op)
                tcm_pkg::OP_CLEAR:
                begin
                    count_next   = '0;
                    seen_next    = '0;
                    win_next     = 1'b0;
                    box_next     = 1'b0;
                    dia_next     = 1'b0;
                    verdict_next = 1'b0;
                end
                tcm_pkg::OP_ADD:
                begin
                    verdict_next = win_reg;
                    if (add_ok)
                    begin
                        accepted_next      = 1'b1;
                        count_next         = count_reg + 1'b1;
                        seen_next[wr_slot] = 1'b0;
                        if (new_kind == tcm_pkg::KIND_ALWAYS)
                        begin
                            box_next = 1'b1;
                        end
                        if (new_kind == tcm_pkg::KIND_EVENTUALLY)
                        begin
                            dia_next = 1'b1;
                        end
                    end
                end
                tcm_pkg::OP_EVAL:
                begin
                    // absent state passes; a walk overwrites this
                    verdict_next = 1'b1;
                end
                default:
                begin
                    verdict_next = win_reg;
                end
            endcase
        end
        else if (cmd.visit)
        begin
            priority if (walk_end)
            begin
                win_next     = 1'b1;
                verdict_next = 1'b1;
            end
            else if (slot_fail)
            begin
                win_next     = 1'b0;
                verdict_next = 1'b0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
                if (kind_mem[rd_slot] == tcm_pkg::KIND_EVENTUALLY)
                begin
                    // clear at the end of a play, otherwise latch a match
                    if (final_reg)
                    begin
                        seen_next[rd_slot] = 1'b0;
                    end
                    else if (match)
                    begin
                        seen_next[rd_slot] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            seen_reg     <= '0;
            win_reg      <= 1'b0;
            box_reg      <= 1'b0;
            dia_reg      <= 1'b0;
            verdict_reg  <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            seen_reg     <= seen_next;
            win_reg      <= win_next;
            box_reg      <= box_next;
            dia_reg      <= dia_next;
            verdict_reg  <= verdict_next;
            accepted_reg <= accepted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg  <= state_bits;
            final_reg <= final_state;
        end
        if (cmd.load && (op == tcm_pkg::OP_ADD) && add_ok)
        begin
            node_mem[wr_slot]   <= node_index;
            set_mem[wr_slot]    <= set_index;
            wanted_mem[wr_slot] <= ~constraint_code[0];
            kind_mem[wr_slot]   <= new_kind;
        end
    end

    assign verdict          = verdict_reg;
    assign accepted         = accepted_reg;
    assign has_box          = box_reg;
    assign has_diamond      = dia_reg;
    assign constraint_count = 4'(count_reg);

    `TCM_NEVER(a_count_in_range, clk, rst_n, int'(count_reg) > MAXC, "constraint count beyond table")
    `TCM_NEVER(a_ptr_within_count, clk, rst_n, cmd.visit && (ptr_reg > count_reg), "walk pointer past table")
    `TCM_ASSERT(a_fail_clears_win, clk, rst_n, (cmd.visit && !walk_end && slot_fail) |=> (!win_reg && !verdict_reg), "failed walk left win set")

endmodule
